// ----- sv/cpfs_pkg.sv -----
// common ppm tuning word scaler: shared types and constants
// no dependencies; imported by every module of the block
package cpfs_pkg;

  // configuration register indexes
  localparam logic REG_NOMINAL_A = 1'b0;
  localparam logic REG_NOMINAL_B = 1'b1;

  // side information that travels down the pipe with each transaction
  typedef struct packed {
    logic neg;       // active word below nominal
    logic zero_nom;  // a nominal register was zero
    logic ovf;       // quotient does not fit in a word
  } cpfs_tag_t;

endpackage

// ----- sv/cpfs_front.sv -----
// front end: offset magnitude, split multiply, rounding add and overflow check
// depends on cpfs_pkg; feeds the first step of the divider chain
module cpfs_front #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [W-1:0]        in_word,
  input  logic [W-1:0]        na,
  input  logic [W-1:0]        nb,
  output logic                out_v,
  output logic [W-1:0]        out_rem,
  output logic [W-1:0]        out_lq,
  output cpfs_pkg::cpfs_tag_t out_tag
);
  import cpfs_pkg::*;

  localparam int H  = (W + 1) / 2;
  localparam int L  = W - H;
  localparam int DW = 2 * W + 1;

  // stage 1: offset magnitude
  logic            v1_r;
  logic [W-1:0]    mag_r, mag_nxt;
  cpfs_tag_t       tag1_r, tag1_nxt;

  // stage 2: partial products
  logic            v2_r;
  logic [W+H-1:0]  pp_lo_r;
  logic [W+L-1:0]  pp_hi_r;
  cpfs_tag_t       tag2_r;

  // stage 3: dividend with rounding term
  logic            v3_r;
  logic [DW-1:0]   div_r, div_nxt;
  cpfs_tag_t       tag3_r;

  // stage 4: overflow check, split into remainder and shift word
  logic            v4_r;
  logic [W-1:0]    rem_r, lq_r;
  cpfs_tag_t       tag4_r, tag4_nxt;

  always_comb begin
    tag1_nxt.zero_nom = (na == '0) || (nb == '0);
    tag1_nxt.ovf      = 1'b0;
    if (in_word >= na) begin
      mag_nxt      = in_word - na;
      tag1_nxt.neg = 1'b0;
    end else begin
      mag_nxt      = na - in_word;
      tag1_nxt.neg = 1'b1;
    end
  end

  always_comb begin
    div_nxt = DW'(pp_lo_r) + (DW'(pp_hi_r) << H) + DW'(na >> 1);
  end

  always_comb begin
    tag4_nxt     = tag3_r;
    tag4_nxt.ovf = div_r[DW-1:W] >= {1'b0, na};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r   <= mag_nxt;
      tag1_r  <= tag1_nxt;
      pp_lo_r <= mag_r * nb[H-1:0];
      pp_hi_r <= mag_r * nb[W-1:H];
      tag2_r  <= tag1_r;
      div_r   <= div_nxt;
      tag3_r  <= tag2_r;
      rem_r   <= div_r[2*W-1:W];
      lq_r    <= div_r[W-1:0];
      tag4_r  <= tag4_nxt;
    end
  end

  assign out_v   = v4_r;
  assign out_rem = rem_r;
  assign out_lq  = lq_r;
  assign out_tag = tag4_r;

endmodule

// ----- sv/cpfs_div_step.sv -----
// one registered restoring division step: one quotient bit per stage
// depends on cpfs_pkg; chained by the top level
module cpfs_div_step #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [W-1:0]        na,
  input  logic                v_i,
  input  logic [W-1:0]        rem_i,
  input  logic [W-1:0]        lq_i,
  input  cpfs_pkg::cpfs_tag_t tag_i,
  output logic                v_o,
  output logic [W-1:0]        rem_o,
  output logic [W-1:0]        lq_o,
  output cpfs_pkg::cpfs_tag_t tag_o
);
  import cpfs_pkg::*;

  logic            v_r;
  logic [W-1:0]    rem_r, rem_nxt;
  logic [W-1:0]    lq_r, lq_nxt;
  cpfs_tag_t       tag_r;
  logic [W:0]      trial;
  logic [W:0]      diff;
  logic            ge;

  // lq holds the dividend bits still to come on top, quotient bits below
  always_comb begin
    trial   = {rem_i, lq_i[W-1]};
    diff    = trial - {1'b0, na};
    ge      = trial >= {1'b0, na};
    rem_nxt = ge ? diff[W-1:0] : trial[W-1:0];
    lq_nxt  = {lq_i[W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      lq_r  <= lq_nxt;
      tag_r <= tag_i;
    end
  end

  assign v_o   = v_r;
  assign rem_o = rem_r;
  assign lq_o  = lq_r;
  assign tag_o = tag_r;

endmodule

// ----- sv/common_ppm_ftw_scaler.sv -----
// common ppm tuning word scaler: top level, config registers, divider chain,
// final add and range check; depends on cpfs_pkg, cpfs_front, cpfs_div_step
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+-----------------
//   input   | in_active_word_a                        | in_valid/in_ready
//   result  | out_active_word_b, out_range_error      | out_valid/out_ready
//   config  | cfg_index, cfg_wdata                    | cfg_wr_en, no wait
//
// one transaction per cycle while the pipe advances; four front stages,
// one divider stage per quotient bit, one output register
// the whole pipe advances together; it holds only while the output register
// is full and out_ready is low, so in_ready = !out_valid || out_ready
// synchronous active-low reset clears the valid bits and both nominal words
module common_ppm_ftw_scaler #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [WORD_BITS-1:0] in_active_word_a,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [WORD_BITS-1:0] out_active_word_b,
  output logic                 out_range_error,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_index,
  input  logic [WORD_BITS-1:0] cfg_wdata
);
  import cpfs_pkg::*;

  localparam int W = WORD_BITS;

  logic [W-1:0] nominal_word_a_r;
  logic [W-1:0] nominal_word_b_r;
  logic         en;

  logic         v_s   [0:W];
  logic [W-1:0] rem_s [0:W];
  logic [W-1:0] lq_s  [0:W];
  cpfs_tag_t    tag_s [0:W];

  logic         out_valid_r;
  logic [W-1:0] out_word_r, out_word_nxt;
  logic         out_err_r, out_err_nxt;
  logic [W:0]   pos_sum;
  logic [W-1:0] quo;
  cpfs_tag_t    last_tag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nominal_word_a_r <= '0;
      nominal_word_b_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_NOMINAL_A: nominal_word_a_r <= cfg_wdata;
        REG_NOMINAL_B: nominal_word_b_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  cpfs_front #(.W(W)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_word  (in_active_word_a),
    .na       (nominal_word_a_r),
    .nb       (nominal_word_b_r),
    .out_v    (v_s[0]),
    .out_rem  (rem_s[0]),
    .out_lq   (lq_s[0]),
    .out_tag  (tag_s[0])
  );

  for (genvar i = 0; i < W; i++) begin : g_div
    cpfs_div_step #(.W(W)) u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .na    (nominal_word_a_r),
      .v_i   (v_s[i]),
      .rem_i (rem_s[i]),
      .lq_i  (lq_s[i]),
      .tag_i (tag_s[i]),
      .v_o   (v_s[i+1]),
      .rem_o (rem_s[i+1]),
      .lq_o  (lq_s[i+1]),
      .tag_o (tag_s[i+1])
    );
  end

  // final offset applied to the nominal word of oscillator b
  always_comb begin
    quo      = lq_s[W];
    last_tag = tag_s[W];
    pos_sum  = {1'b0, nominal_word_b_r} + {1'b0, quo};
    if (last_tag.neg) begin
      out_err_nxt  = last_tag.zero_nom || last_tag.ovf || (quo >= nominal_word_b_r);
      out_word_nxt = nominal_word_b_r - quo;
    end else begin
      out_err_nxt  = last_tag.zero_nom || last_tag.ovf || pos_sum[W];
      out_word_nxt = pos_sum[W-1:0];
    end
    if (out_err_nxt) begin
      out_word_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_s[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word_r <= out_word_nxt;
      out_err_r  <= out_err_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_active_word_b = out_word_r;
  assign out_range_error   = out_err_r;

  // an error transaction always carries a zero word
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_word_r == '0)
    else $error("range error with nonzero word");

  // a good result is never zero
  a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_err_r |-> out_word_r != '0)
    else $error("zero word without range error");

  // zero nominal register must surface as an error
  a_zero_nom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (nominal_word_a_r == '0 || nominal_word_b_r == '0) |-> out_err_r)
    else $error("zero nominal word not flagged");

  // a held result stays put while the pipe is frozen
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_word_r) && $stable(v_s[W]))
    else $error("pipe moved during stall");

endmodule
